// File: rtl/tppp_pkg.sv
// ----------------------------------------------------------------------------
// tppp_pkg
// Shared constants and types for the threshold page pixel packer.
// ----------------------------------------------------------------------------
package tppp_pkg;

   // image limits
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 4096;

   // counter and buffer address widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);

   // register and field widths
   localparam int WIDTH_REG_W  = 9;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int PIXEL_W      = 8;
   localparam int BYTE_W       = 8;
   localparam int COLUMN_W     = 8;
   localparam int PAGE_W       = 9;

   // page geometry
   localparam int PAGE_ROWS  = 8;
   localparam int BIT_POS_W  = $clog2(PAGE_ROWS);
   localparam logic [PIXEL_W-1:0] DARK_LIMIT = 8'd128;

   // register reset values
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 9'd128;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd64;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // one pixel after thresholding and position decode
   typedef struct packed {
      logic                 dark;
      logic [COL_W-1:0]     slot;
      logic [BIT_POS_W-1:0] bit_pos;
      logic                 emit;
      logic [PAGE_W-1:0]    page;
      logic                 done;
   } tppp_item_type;

endpackage

// File: rtl/tppp_ram.sv
// ----------------------------------------------------------------------------
// tppp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tppp_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tppp_front.sv
// ----------------------------------------------------------------------------
// tppp_front
// Size registers, column and row counters, and pixel position decode.
// ----------------------------------------------------------------------------
module tppp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [tppp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tppp_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                accept,
   input  logic [tppp_pkg::PIXEL_W-1:0]        pixel_value,
   output tppp_pkg::tppp_item_type             item
);

   logic [tppp_pkg::WIDTH_REG_W-1:0]  image_width_ff, image_width_in;
   logic [tppp_pkg::HEIGHT_REG_W-1:0] image_height_ff, image_height_in;
   logic [tppp_pkg::COL_W-1:0]        column_count_ff, column_count_in;
   logic [tppp_pkg::ROW_W-1:0]        row_count_ff, row_count_in;

   logic [tppp_pkg::WIDTH_REG_W-1:0]  width_eff;
   logic [tppp_pkg::HEIGHT_REG_W-1:0] height_eff;
   logic [tppp_pkg::WIDTH_REG_W-1:0]  col_wide;
   logic [tppp_pkg::HEIGHT_REG_W-1:0] row_next_wide;
   logic [tppp_pkg::COL_W-1:0]        col;
   logic                              last_col;
   logic                              last_row;

   // register writes
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write_en) begin
         case (csr_index)
            tppp_pkg::CSR_IMAGE_WIDTH:
               image_width_in = csr_write_data[tppp_pkg::WIDTH_REG_W-1:0];
            tppp_pkg::CSR_IMAGE_HEIGHT:
               image_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // clamp sizes: zero acts as one, too large acts as the maximum
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = tppp_pkg::WIDTH_REG_W'(1);
      end else if (image_width_ff > tppp_pkg::WIDTH_REG_W'(tppp_pkg::MAX_WIDTH)) begin
         width_eff = tppp_pkg::WIDTH_REG_W'(tppp_pkg::MAX_WIDTH);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = tppp_pkg::HEIGHT_REG_W'(1);
      end else if (image_height_ff > tppp_pkg::HEIGHT_REG_W'(tppp_pkg::MAX_HEIGHT)) begin
         height_eff = tppp_pkg::HEIGHT_REG_W'(tppp_pkg::MAX_HEIGHT);
      end else begin
         height_eff = image_height_ff;
      end
   end

   // position of this pixel, column pulled back inside a shrunk row
   always_comb begin
      col_wide = tppp_pkg::WIDTH_REG_W'(column_count_ff);
      if (col_wide >= width_eff) begin
         col_wide = width_eff - tppp_pkg::WIDTH_REG_W'(1);
      end
      col           = col_wide[tppp_pkg::COL_W-1:0];
      last_col      = (col_wide == width_eff - tppp_pkg::WIDTH_REG_W'(1));
      row_next_wide = tppp_pkg::HEIGHT_REG_W'(row_count_ff) + tppp_pkg::HEIGHT_REG_W'(1);
      last_row      = (row_next_wide >= height_eff);
   end

   // decoded item
   always_comb begin
      item.dark    = (pixel_value < tppp_pkg::DARK_LIMIT);
      item.slot    = col;
      item.bit_pos = row_count_ff[tppp_pkg::BIT_POS_W-1:0];
      item.emit    = (row_count_ff[tppp_pkg::BIT_POS_W-1:0] ==
                      tppp_pkg::BIT_POS_W'(tppp_pkg::PAGE_ROWS - 1)) || last_row;
      item.page    = tppp_pkg::PAGE_W'(row_count_ff >> tppp_pkg::BIT_POS_W);
      item.done    = last_row && last_col;
   end

   // raster counters
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (last_col) begin
            column_count_in = '0;
            row_count_in    = last_row ? '0 : row_next_wide[tppp_pkg::ROW_W-1:0];
         end else begin
            column_count_in = col + tppp_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= tppp_pkg::WIDTH_RESET;
         image_height_ff <= tppp_pkg::HEIGHT_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule

// File: rtl/tppp_pack.sv
// ----------------------------------------------------------------------------
// tppp_pack
// Page buffer read-modify-write with forwarding, and the result register.
// ----------------------------------------------------------------------------
module tppp_pack (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_accept,
   input  tppp_pkg::tppp_item_type        in_item,
   output logic                           in_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tppp_pkg::BYTE_W-1:0]    rsp_packed_byte,
   output logic [tppp_pkg::COLUMN_W-1:0]  rsp_byte_column,
   output logic [tppp_pkg::PAGE_W-1:0]    rsp_page_index,
   output logic                           rsp_image_done
);

   logic                           s1_valid_ff, s1_valid_in;
   tppp_pkg::tppp_item_type        s1_item_ff;
   logic                           fwd_hit_ff, fwd_hit_in;
   logic [tppp_pkg::BYTE_W-1:0]    fwd_data_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tppp_pkg::BYTE_W-1:0]    rsp_packed_byte_ff;
   logic [tppp_pkg::COLUMN_W-1:0]  rsp_byte_column_ff;
   logic [tppp_pkg::PAGE_W-1:0]    rsp_page_index_ff;
   logic                           rsp_image_done_ff;

   logic [tppp_pkg::BYTE_W-1:0]    ram_rd_data;
   logic [tppp_pkg::BYTE_W-1:0]    base_byte;
   logic [tppp_pkg::BYTE_W-1:0]    dark_bit;
   logic [tppp_pkg::BYTE_W-1:0]    new_byte;
   logic                           out_free;
   logic                           s1_go;

   // page buffer, read at accept and written when the item leaves
   tppp_ram #(
      .DATA_W (tppp_pkg::BYTE_W),
      .DEPTH  (tppp_pkg::MAX_WIDTH)
   ) u_page_buffer (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_item_ff.slot),
      .wr_data (new_byte),
      .rd_en   (in_accept),
      .rd_addr (in_item.slot),
      .rd_data (ram_rd_data)
   );

   // merge the new bit; the first row of a page starts from zero
   always_comb begin
      base_byte = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
      dark_bit  = s1_item_ff.dark ? (tppp_pkg::BYTE_W'(1) << s1_item_ff.bit_pos) : '0;
      if (s1_item_ff.bit_pos == '0) begin
         new_byte = dark_bit;
      end else begin
         new_byte = base_byte | dark_bit;
      end
   end

   // flow control
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && (!s1_item_ff.emit || out_free);
   assign in_stall = s1_valid_ff && !s1_go;

   // stage occupancy and write forwarding
   always_comb begin
      s1_valid_in = s1_valid_ff;
      fwd_hit_in  = fwd_hit_ff;
      if (in_accept) begin
         s1_valid_in = 1'b1;
         fwd_hit_in  = s1_go && (s1_item_ff.slot == in_item.slot);
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
         fwd_hit_in  = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_item_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_item_ff  <= in_item;
         fwd_data_ff <= new_byte;
      end
      if (s1_go && s1_item_ff.emit) begin
         rsp_packed_byte_ff <= new_byte;
         rsp_byte_column_ff <= tppp_pkg::COLUMN_W'(s1_item_ff.slot);
         rsp_page_index_ff  <= s1_item_ff.page;
         rsp_image_done_ff  <= s1_item_ff.done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_byte = rsp_packed_byte_ff;
   assign rsp_byte_column = rsp_byte_column_ff;
   assign rsp_page_index  = rsp_page_index_ff;
   assign rsp_image_done  = rsp_image_done_ff;

   // forwarding only applies to an item held in the stage
   assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff)
      else $error("forward hit without an item in the stage");

   // a blocked stage keeps its item and buffer slot
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("stalled stage lost its item");

   // an emitting item that leaves lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_item_ff.emit) |=> rsp_valid_ff)
      else $error("emitted byte missing from result register");

   // the stage never overwrites a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && s1_valid_ff && s1_item_ff.emit) |-> !s1_go)
      else $error("result overwritten while stalled");

endmodule

// File: rtl/threshold_page_pixel_packer.sv
// ----------------------------------------------------------------------------
// threshold_page_pixel_packer
// Thresholds grey pixels and packs them into vertical page bytes.
// ----------------------------------------------------------------------------
// Feed pixels in raster order, top row first. Each pixel below 128 sets its
// row's bit in the byte of its column; on the eighth row of a page, or on the
// last image row, each pixel returns its column's finished byte with column,
// page and an end-of-image flag. One pixel is taken every clock cycle unless
// a waiting result stalls the stage; a pixel's byte passes through the stage
// register into the result register. The rate is set by the page buffer RAM,
// read when a request is taken and written when its item leaves the stage,
// with a forwarding register for back-to-back pixels of one column. Sizes must be
// written over the csr port only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module threshold_page_pixel_packer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [tppp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tppp_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tppp_pkg::PIXEL_W-1:0]        req_pixel_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tppp_pkg::BYTE_W-1:0]         rsp_packed_byte,
   output logic [tppp_pkg::COLUMN_W-1:0]       rsp_byte_column,
   output logic [tppp_pkg::PAGE_W-1:0]         rsp_page_index,
   output logic                                rsp_image_done
);

   logic                    req_accept;
   tppp_pkg::tppp_item_type item;

   assign req_accept = req_valid && !req_stall;

   // counters, sizes and decode
   tppp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .accept         (req_accept),
      .pixel_value    (req_pixel_value),
      .item           (item)
   );

   // buffer update and result
   tppp_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .in_accept       (req_accept),
      .in_item         (item),
      .in_stall        (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_byte_column (rsp_byte_column),
      .rsp_page_index  (rsp_page_index),
      .rsp_image_done  (rsp_image_done)
   );

endmodule

// File: dv/tb_threshold_page_pixel_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_page_pixel_packer
// Self-checking bench for the threshold page pixel packer.
// ----------------------------------------------------------------------------
// Pixels are pushed through the request channel with random gaps while the
// response side stalls at random. A behavioral packer in the bench keeps its
// own page buffer, counters and image size, and queues the page byte each
// accepted pixel should produce. Every response is checked field by field
// against the oldest queued byte. Directed cases cover the reset geometry,
// clamped sizes, counters left past a shrunken image and the widest row;
// random images with random sizes follow.
// ----------------------------------------------------------------------------
module tb_threshold_page_pixel_packer;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_ITEMS  = 180;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_WAIT      = 14;
   localparam int MAX_REPORTS   = 10;

   // indexes past the register list, writes there are dropped
   localparam logic [tppp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [tppp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [tppp_pkg::BYTE_W-1:0]   packed_byte;
      logic [tppp_pkg::COLUMN_W-1:0] column;
      logic [tppp_pkg::PAGE_W-1:0]   page;
      logic                          done;
   } page_byte_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_write_en = 1'b0;
   logic [tppp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tppp_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [tppp_pkg::PIXEL_W-1:0]     req_pixel_value = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [tppp_pkg::BYTE_W-1:0]      rsp_packed_byte;
   logic [tppp_pkg::COLUMN_W-1:0]    rsp_byte_column;
   logic [tppp_pkg::PAGE_W-1:0]      rsp_page_index;
   logic                             rsp_image_done;

   // packer state as the bench sees it
   logic [tppp_pkg::WIDTH_REG_W-1:0]  width_reg  = tppp_pkg::WIDTH_RESET;
   logic [tppp_pkg::HEIGHT_REG_W-1:0] height_reg = tppp_pkg::HEIGHT_RESET;
   logic [tppp_pkg::BYTE_W-1:0]       page_mem [tppp_pkg::MAX_WIDTH];
   int                                col_pos = 0;
   int                                row_pos = 0;
   page_byte_type                     expected_bytes [$];

   int mismatches  = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   bit steady      = 1'b0;

   threshold_page_pixel_packer dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_byte_column (rsp_byte_column),
      .rsp_page_index  (rsp_page_index),
      .rsp_image_done  (rsp_image_done)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL threshold_page_pixel_packer");
         $finish;
      end
   end

   // zero and oversized sizes fold into the legal range
   function automatic int eff_dim(input int v, input int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // grey level, biased toward the dark limit and the ends of the range
   function automatic logic [tppp_pkg::PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 5))
         0:       return tppp_pkg::PIXEL_W'($urandom_range(120, 135));
         1:       return $urandom_range(0, 1) ? 8'd0 : 8'd255;
         default: return tppp_pkg::PIXEL_W'($urandom);
      endcase
   endfunction

   // threshold one pixel into the page buffer and queue the byte it emits
   function automatic void pack_pixel(input logic [tppp_pkg::PIXEL_W-1:0] pix);
      int w, h, col, bit_pos;
      logic last_col, last_row;
      logic [tppp_pkg::BYTE_W-1:0] dark_bit;
      page_byte_type b;
      w = eff_dim(width_reg, tppp_pkg::MAX_WIDTH);
      h = eff_dim(height_reg, tppp_pkg::MAX_HEIGHT);
      // a column left past a shrunken width ends its row
      col = (col_pos >= w) ? w - 1 : col_pos;
      bit_pos = row_pos % tppp_pkg::PAGE_ROWS;
      last_col = (col + 1 >= w);
      last_row = (row_pos + 1 >= h);
      dark_bit = (pix < tppp_pkg::DARK_LIMIT) ? (tppp_pkg::BYTE_W'(1) << bit_pos) : '0;
      if (bit_pos == 0) page_mem[col] = dark_bit;
      else page_mem[col] = page_mem[col] | dark_bit;
      if (bit_pos == tppp_pkg::PAGE_ROWS - 1 || last_row) begin
         b.packed_byte = page_mem[col];
         b.column      = tppp_pkg::COLUMN_W'(col);
         b.page        = tppp_pkg::PAGE_W'(row_pos / tppp_pkg::PAGE_ROWS);
         b.done        = last_row && last_col;
         expected_bytes.push_back(b);
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col + 1;
      end
   endfunction

   // one pixel request, held until the packer takes it
   task automatic send_pixel(input logic [tppp_pkg::PIXEL_W-1:0] pix);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      do @(posedge clock); while (req_stall);
      pack_pixel(pix);
   endtask

   // drain all bytes, then give the pipeline time to empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves the write enable high, configure drops it
   task automatic write_reg(input logic [tppp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tppp_pkg::CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         tppp_pkg::CSR_IMAGE_WIDTH:  width_reg = data[tppp_pkg::WIDTH_REG_W-1:0];
         tppp_pkg::CSR_IMAGE_HEIGHT: height_reg = data[tppp_pkg::HEIGHT_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [tppp_pkg::CSR_DATA_W-1:0] wdata,
                            input logic [tppp_pkg::CSR_DATA_W-1:0] hdata);
      settle();
      write_reg($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                tppp_pkg::CSR_DATA_W'($urandom));
      write_reg(tppp_pkg::CSR_IMAGE_WIDTH, wdata);
      write_reg(tppp_pkg::CSR_IMAGE_HEIGHT, hdata);
      csr_write_en <= 1'b0;
   endtask

   // response side stall, drawn fresh after every accepted byte
   always @(posedge clock) begin : stall_rsp
      int w;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         w = draw_wait();
         stall_left <= w;
         rsp_stall  <= (w != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   // compare each accepted byte with the oldest expected one
   always @(posedge clock) begin : check_bytes
      page_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected byte %02h col %0d page %0d done %0b",
                        rsp_packed_byte, rsp_byte_column, rsp_page_index,
                        rsp_image_done);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_packed_byte !== want.packed_byte || rsp_byte_column !== want.column ||
                rsp_page_index !== want.page || rsp_image_done !== want.done) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"byte mismatch: expected %02h col %0d page %0d done %0b,",
                            " got %02h col %0d page %0d done %0b"},
                           want.packed_byte, want.column, want.page, want.done,
                           rsp_packed_byte, rsp_byte_column, rsp_page_index,
                           rsp_image_done);
            end
         end
      end
   end

   // reset size, first pixels of a row give no byte
   task automatic test_reset_geometry();
      send_pixel(8'd0);
      send_pixel(8'd127);
      send_pixel(8'd128);
      send_pixel(8'd255);
   endtask

   // width shrinks under the current column, zero height acts as one row
   task automatic test_column_past_width();
      configure(13'd3, 13'd0);
      send_pixel(8'd0);
      send_pixel(8'd127);
      send_pixel(8'd128);
      send_pixel(8'd0);
   endtask

   // zero width acts as one column, oversized height clamps
   task automatic test_single_column_page();
      logic [tppp_pkg::PIXEL_W-1:0] pattern [8] = '{8'd0, 8'd255, 8'd127, 8'd128,
                                                    8'd1, 8'd254, 8'd100, 8'd200};
      configure(13'd0, 13'd8191);
      foreach (pattern[i]) send_pixel(pattern[i]);
   endtask

   // height shrinks under the current row: partial page, then a short image
   task automatic test_row_past_height();
      configure(13'd0, 13'd3);
      send_pixel(8'd0);
      send_pixel(8'd50);
      send_pixel(8'd128);
      send_pixel(8'd127);
   endtask

   // upper write bits dropped, width clamps to the maximum, one row
   task automatic test_widest_row();
      configure(13'h1FFF, 13'd1);
      repeat (tppp_pkg::MAX_WIDTH) send_pixel(random_pixel());
   endtask

   // random sizes, mostly whole small images
   task automatic test_random_images();
      int sent, n, w, h, rows_left, cols_left, remaining;
      logic [tppp_pkg::CSR_DATA_W-1:0] wdata, hdata;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       wdata = '0;
            1:       wdata = {4'($urandom), 9'($urandom_range(1, 12))};
            2:       wdata = tppp_pkg::CSR_DATA_W'($urandom_range(13, 40));
            3:       wdata = tppp_pkg::CSR_DATA_W'($urandom_range(257, 511));
            default: wdata = tppp_pkg::CSR_DATA_W'($urandom_range(1, 10));
         endcase
         case ($urandom_range(0, 7))
            0:       hdata = '0;
            1:       hdata = tppp_pkg::CSR_DATA_W'($urandom_range(13, 8191));
            default: hdata = tppp_pkg::CSR_DATA_W'($urandom_range(1, 12));
         endcase
         // a width that grows inside a page would read bytes it never wrote
         if (eff_dim(wdata[tppp_pkg::WIDTH_REG_W-1:0], tppp_pkg::MAX_WIDTH) >
             eff_dim(width_reg, tppp_pkg::MAX_WIDTH) &&
             row_pos % tppp_pkg::PAGE_ROWS != 0)
            wdata = tppp_pkg::CSR_DATA_W'(width_reg);
         configure(wdata, hdata);
         steady = ($urandom_range(0, 3) == 0);
         w = eff_dim(width_reg, tppp_pkg::MAX_WIDTH);
         h = eff_dim(height_reg, tppp_pkg::MAX_HEIGHT);
         rows_left = (row_pos >= h) ? 1 : h - row_pos;
         cols_left = (col_pos >= w) ? 1 : w - col_pos;
         remaining = cols_left + (rows_left - 1) * w;
         if (remaining <= 80 && $urandom_range(0, 3) != 0) n = remaining;
         else n = $urandom_range(1, 30);
         repeat (n) send_pixel(random_pixel());
         sent += n;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_column_past_width();
      test_single_column_page();
      test_row_past_height();
      test_widest_row();
      test_random_images();
      settle();
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("PASS threshold_page_pixel_packer");
      end else begin
         $display("FAIL threshold_page_pixel_packer");
      end
      $finish;
   end

endmodule
